@@ rtl/epc_pkg.sv @@
// Shared constants, state codes and control types for the equal pair counter.
package epc_pkg;

  localparam int MAX_ITEMS   = 1024;
  localparam int KEY_BITS    = 36;
  localparam int KEY_VALUE_W = 36;
  localparam int PAIR_W      = 19;
  localparam int ADDR_W      = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CNT_W       = $clog2(MAX_ITEMS + 1);

  localparam logic [PAIR_W-1:0] PAIR_MAX = {PAIR_W{1'b1}};
  localparam logic [CNT_W-1:0]  HELD_MAX = CNT_W'(MAX_ITEMS);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_EMIT = 3'b100
  } epc_state_t;

  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic              cmp_en;
    logic              acc_clr;
    logic              emit;
  } epc_ctrl_t;

endpackage

@@ rtl/epc_ifs.sv @@
// Valid/ready channel interfaces for key words and result words.
interface epc_in_if;
  logic                            valid;
  logic                            ready;
  logic [epc_pkg::KEY_VALUE_W-1:0] key_value;
  logic                            set_end;

  modport source (output valid, output key_value, output set_end, input ready);
  modport sink (input valid, input key_value, input set_end, output ready);
endinterface

interface epc_out_if;
  logic                       valid;
  logic                       ready;
  logic [epc_pkg::PAIR_W-1:0] pair_count;
  logic                       overflowed;

  modport source (output valid, output pair_count, output overflowed, input ready);
  modport sink (input valid, input pair_count, input overflowed, output ready);
endinterface

@@ rtl/equal_pair_counter_core.sv @@
// Equal pair counter: counts pairs of equal keys in each set of keys.
// Usage:
//   in_ch carries one key word per handshake; set_end marks the last key of
//   a set. out_ch carries one result word per set: the number of unordered
//   pairs of equal keys and a flag that keys were dropped for lack of room.
//   Each accepted key is compared against every key already held in the set,
//   one stored key per cycle through a single comparator fed by the key
//   store's read port, and is then written behind them.
//   in_ch is not ready while a key is being compared and written.
//   A key that arrives with the store full is dropped without a compare.
//   Once the last key of a set is handled, the block loads the result word into
//   the output register, which shows it on out_ch the cycle after. The word
//   sits there until out_ch takes it; the next set's keys are accepted
//   meanwhile. A second result waits inside the block, with in_ch not ready,
//   until the first has been taken.
//   Reset (rst_n low, synchronous) empties the set, clears the count and
//   drops any pending result. The key store itself is not cleared.
module equal_pair_counter_core (
  input  logic       clk,
  input  logic       rst_n,
  epc_in_if.sink     in_ch,
  epc_out_if.source  out_ch
);

  epc_pkg::epc_ctrl_t           ctl;
  logic [epc_pkg::KEY_BITS-1:0] key;
  logic [epc_pkg::KEY_BITS-1:0] stored_key;
  logic [epc_pkg::PAIR_W-1:0]   pairs;
  logic                         dropped;
  logic                         out_free;
  logic                         out_valid_r;
  logic [epc_pkg::PAIR_W-1:0]   pair_count_r;
  logic                         overflowed_r;

  assign out_free = !out_valid_r || out_ch.ready;

  epc_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_key_value (in_ch.key_value),
    .in_set_end   (in_ch.set_end),
    .in_ready     (in_ch.ready),
    .out_free     (out_free),
    .ctl          (ctl),
    .key          (key),
    .dropped      (dropped)
  );

  epc_key_ram u_ram (
    .clk     (clk),
    .wr_en   (ctl.wr_en),
    .wr_addr (ctl.wr_addr),
    .wr_data (key),
    .rd_en   (ctl.rd_en),
    .rd_addr (ctl.rd_addr),
    .rd_data (stored_key)
  );

  epc_match_unit u_match (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmp_en     (ctl.cmp_en),
    .acc_clr    (ctl.acc_clr),
    .key        (key),
    .stored_key (stored_key),
    .pairs      (pairs)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      pair_count_r <= pairs;
      overflowed_r <= dropped;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.pair_count = pair_count_r;
  assign out_ch.overflowed = overflowed_r;

endmodule

@@ rtl/epc_key_ram.sv @@
// Key store: one write port and one registered read port.
module epc_key_ram (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [epc_pkg::ADDR_W-1:0]   wr_addr,
  input  logic [epc_pkg::KEY_BITS-1:0] wr_data,
  input  logic                         rd_en,
  input  logic [epc_pkg::ADDR_W-1:0]   rd_addr,
  output logic [epc_pkg::KEY_BITS-1:0] rd_data
);

  logic [epc_pkg::KEY_BITS-1:0] mem [epc_pkg::MAX_ITEMS];
  logic [epc_pkg::KEY_BITS-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/epc_match_unit.sv @@
// Shared compare unit with a saturating pair accumulator.
module epc_match_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cmp_en,
  input  logic                         acc_clr,
  input  logic [epc_pkg::KEY_BITS-1:0] key,
  input  logic [epc_pkg::KEY_BITS-1:0] stored_key,
  output logic [epc_pkg::PAIR_W-1:0]   pairs
);

  logic [epc_pkg::PAIR_W-1:0] pairs_r;
  logic [epc_pkg::PAIR_W-1:0] pairs_nxt;
  logic                       hit;

  assign hit = cmp_en && (key == stored_key);

  // Saturating one match at a time gives the same result as saturating the sum.
  always_comb begin
    pairs_nxt = pairs_r;
    if (acc_clr) begin
      pairs_nxt = '0;
    end else if (hit && (pairs_r != epc_pkg::PAIR_MAX)) begin
      pairs_nxt = pairs_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pairs_r <= '0;
    end else begin
      pairs_r <= pairs_nxt;
    end
  end

  assign pairs = pairs_r;

`ifndef NO_ASSERTIONS
  a_sat_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (pairs_r == epc_pkg::PAIR_MAX) && !acc_clr |=> pairs_r == epc_pkg::PAIR_MAX)
    else $error("pair count left saturation without a clear");
  a_clr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    acc_clr |=> pairs_r == '0)
    else $error("pair count not zero after clear");
  a_step_one: assert property (@(posedge clk) disable iff (!rst_n)
    !acc_clr |=> (pairs_r == $past(pairs_r)) || (pairs_r == $past(pairs_r) + 1'b1))
    else $error("pair count moved by more than one match");
`endif

endmodule

@@ rtl/epc_ctrl.sv @@
// Sequencer: accepts keys, sweeps the key store, commits keys and closes sets.
module epc_ctrl (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic [epc_pkg::KEY_VALUE_W-1:0] in_key_value,
  input  logic                            in_set_end,
  output logic                            in_ready,
  input  logic                            out_free,
  output epc_pkg::epc_ctrl_t              ctl,
  output logic [epc_pkg::KEY_BITS-1:0]    key,
  output logic                            dropped
);

  epc_pkg::epc_state_t          state_r, state_nxt;
  logic [epc_pkg::CNT_W-1:0]    held_r, held_nxt;
  logic [epc_pkg::CNT_W-1:0]    scan_cnt_r, scan_cnt_nxt;
  logic                         cmp_vld_r, cmp_vld_nxt;
  logic                         drop_r, drop_nxt;
  logic                         last_r;
  logic [epc_pkg::KEY_BITS-1:0] key_r;
  logic                         accept;
  logic                         issue;

  assign in_ready = (state_r == epc_pkg::ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign issue    = (state_r == epc_pkg::ST_SCAN) && (scan_cnt_r < held_r);

  always_comb begin
    state_nxt    = state_r;
    held_nxt     = held_r;
    scan_cnt_nxt = scan_cnt_r;
    drop_nxt     = drop_r;
    cmp_vld_nxt  = issue;
    ctl          = '0;
    ctl.rd_en    = issue;
    ctl.rd_addr  = scan_cnt_r[epc_pkg::ADDR_W-1:0];
    ctl.wr_addr  = held_r[epc_pkg::ADDR_W-1:0];
    ctl.cmp_en   = cmp_vld_r;
    unique case (state_r)
      epc_pkg::ST_IDLE: begin
        if (accept) begin
          if (held_r >= epc_pkg::HELD_MAX) begin
            // Store full: the key is dropped without a compare.
            drop_nxt  = 1'b1;
            state_nxt = in_set_end ? epc_pkg::ST_EMIT : epc_pkg::ST_IDLE;
          end else begin
            scan_cnt_nxt = '0;
            state_nxt    = epc_pkg::ST_SCAN;
          end
        end
      end
      epc_pkg::ST_SCAN: begin
        if (issue) begin
          scan_cnt_nxt = scan_cnt_r + 1'b1;
        end else if (!cmp_vld_r) begin
          // Last compare has landed: store the key behind the others.
          ctl.wr_en = 1'b1;
          held_nxt  = held_r + 1'b1;
          state_nxt = last_r ? epc_pkg::ST_EMIT : epc_pkg::ST_IDLE;
        end
      end
      epc_pkg::ST_EMIT: begin
        if (out_free) begin
          ctl.emit    = 1'b1;
          ctl.acc_clr = 1'b1;
          held_nxt    = '0;
          drop_nxt    = 1'b0;
          state_nxt   = epc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = epc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= epc_pkg::ST_IDLE;
      held_r     <= '0;
      scan_cnt_r <= '0;
      cmp_vld_r  <= 1'b0;
      drop_r     <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      held_r     <= held_nxt;
      scan_cnt_r <= scan_cnt_nxt;
      cmp_vld_r  <= cmp_vld_nxt;
      drop_r     <= drop_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      key_r  <= in_key_value[epc_pkg::KEY_BITS-1:0];
      last_r <= in_set_end;
    end
  end

  assign key     = key_r;
  assign dropped = drop_r;

`ifndef NO_ASSERTIONS
  a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
    held_r <= epc_pkg::HELD_MAX)
    else $error("key count beyond store capacity");
  a_wr_room: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.wr_en |-> held_r < epc_pkg::HELD_MAX)
    else $error("key written into a full store");
  a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.emit |=> (held_r == '0) && !drop_r && (state_r == epc_pkg::ST_IDLE))
    else $error("set not cleared after its result");
  a_cmp_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    cmp_vld_r |-> state_r == epc_pkg::ST_SCAN)
    else $error("compare outside a store sweep");
`endif

endmodule

@@ tb/pair_count_checker.sv @@
// Checker that follows both channels, predicts each set's pair count and compares result words.
`timescale 1ns / 1ps
module pair_count_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  logic [epc_pkg::KEY_VALUE_W-1:0] in_key_value,
  input  logic                            in_set_end,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  logic [epc_pkg::PAIR_W-1:0]      out_pair_count,
  input  logic                            out_overflowed,
  output int                              fail_count,
  output int                              pending_results,
  output int                              keys_seen,
  output int                              results_seen,
  output int                              dropped_sets,
  output int                              top_pair_count
);

  // Only the low KEY_BITS bits of a key take part in the comparison.
  localparam logic [epc_pkg::KEY_VALUE_W-1:0] KEY_MASK =
    {epc_pkg::KEY_VALUE_W{1'b1}} >> ((epc_pkg::KEY_BITS >= epc_pkg::KEY_VALUE_W) ? 0 :
                                     epc_pkg::KEY_VALUE_W - epc_pkg::KEY_BITS);

  typedef struct packed {
    logic [epc_pkg::PAIR_W-1:0] pair_count;
    logic                       overflowed;
  } pair_result_t;

  logic [epc_pkg::KEY_VALUE_W-1:0] held_keys [epc_pkg::MAX_ITEMS];
  int                              held_count;
  logic [epc_pkg::PAIR_W-1:0]      pair_total;
  logic                            keys_dropped;
  pair_result_t                    expected_results [$];
  pair_result_t                    want;

  task automatic report_mismatch(input string msg);
    fail_count++;
    $display("[%0t] MISMATCH: %s", $time, msg);
  endtask

  // Adds one key to the running set; the set's result is queued on its last key.
  task automatic count_key_matches(input logic [epc_pkg::KEY_VALUE_W-1:0] raw_key,
                                   input logic last);
    logic [epc_pkg::KEY_VALUE_W-1:0] key;
    int                              match_cnt;
    int                              i;
    pair_result_t                    res;
    key = raw_key & KEY_MASK;
    if (held_count >= epc_pkg::MAX_ITEMS) begin
      keys_dropped = 1'b1;
    end else begin
      match_cnt = 0;
      for (i = 0; i < held_count; i++) begin
        if (held_keys[i] == key) match_cnt++;
      end
      if (int'(pair_total) + match_cnt > int'(epc_pkg::PAIR_MAX)) begin
        pair_total = epc_pkg::PAIR_MAX;
      end else begin
        pair_total = epc_pkg::PAIR_W'(int'(pair_total) + match_cnt);
      end
      held_keys[held_count] = key;
      held_count++;
    end
    if (last) begin
      res.pair_count = pair_total;
      res.overflowed = keys_dropped;
      expected_results.push_back(res);
      held_count   = 0;
      pair_total   = '0;
      keys_dropped = 1'b0;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      fail_count     = 0;
      keys_seen      = 0;
      results_seen   = 0;
      dropped_sets   = 0;
      top_pair_count = 0;
      held_count     = 0;
      pair_total     = '0;
      keys_dropped   = 1'b0;
      expected_results.delete();
    end else begin
      // A result word can never come from a key taken at the same edge, so check first.
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf(
            "result word with nothing expected: pair_count=%0d overflowed=%0b",
            out_pair_count, out_overflowed));
        end else begin
          want = expected_results.pop_front();
          if (out_pair_count !== want.pair_count)
            report_mismatch($sformatf("pair_count got %0d, want %0d",
                                      out_pair_count, want.pair_count));
          if (out_overflowed !== want.overflowed)
            report_mismatch($sformatf("overflowed got %0b, want %0b",
                                      out_overflowed, want.overflowed));
          if (want.overflowed) dropped_sets++;
          if (int'(want.pair_count) > top_pair_count) top_pair_count = int'(want.pair_count);
        end
      end
      if (in_valid && in_ready) begin
        keys_seen++;
        count_key_matches(in_key_value, in_set_end);
      end
    end
    pending_results = expected_results.size();
  end

endmodule

@@ tb/equal_pair_counter_core_tb.sv @@
// Testbench top: drives key sets into the equal pair counter and reports the verdict.
`timescale 1ns / 1ps
module equal_pair_counter_core_tb;

  localparam int DRAIN_CYCLES = epc_pkg::MAX_ITEMS + 16;
  localparam int HOLD_CYCLES  = 1500;
  localparam int PHASE_ITEMS  = 180;
  localparam logic [epc_pkg::KEY_VALUE_W-1:0] KEY_ONES = {epc_pkg::KEY_VALUE_W{1'b1}};

  logic clk;
  logic rst_n;
  int   send_idle_pct;
  int   recv_idle_pct;
  bit   long_hold_req;
  int   sets_sent;

  int fail_count;
  int pending_results;
  int keys_seen;
  int results_seen;
  int dropped_sets;
  int top_pair_count;

  epc_in_if  in_ch ();
  epc_out_if out_ch ();

  equal_pair_counter_core uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  pair_count_checker u_pair_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_ch.valid),
    .in_ready        (in_ch.ready),
    .in_key_value    (in_ch.key_value),
    .in_set_end      (in_ch.set_end),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_pair_count  (out_ch.pair_count),
    .out_overflowed  (out_ch.overflowed),
    .fail_count      (fail_count),
    .pending_results (pending_results),
    .keys_seen       (keys_seen),
    .results_seen    (results_seen),
    .dropped_sets    (dropped_sets),
    .top_pair_count  (top_pair_count)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #30_000_000;
    $display("Timeout: the run did not finish in time.");
    $display("*** FAILED ***");
    $finish;
  end

  // Result side: random stalls, plus one long hold-off that fills the block.
  initial begin : result_receiver
    int hold_left;
    bit hold_taken;
    hold_left    = 0;
    hold_taken   = 1'b0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_req && !hold_taken) begin
        hold_left  = HOLD_CYCLES;
        hold_taken = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  function automatic logic [epc_pkg::KEY_VALUE_W-1:0] random_key();
    return epc_pkg::KEY_VALUE_W'({$urandom(), $urandom()});
  endfunction

  // Called and returns at a falling edge; valid stays high after the handshake.
  task automatic send_word(input logic [epc_pkg::KEY_VALUE_W-1:0] key, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid     <= 1'b0;
      in_ch.key_value <= random_key();
      in_ch.set_end   <= 1'($urandom_range(1));
      @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.key_value <= key;
    in_ch.set_end   <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_listed(input logic [epc_pkg::KEY_VALUE_W-1:0] keys [$]);
    int i;
    for (i = 0; i < keys.size(); i++) send_word(keys[i], i == keys.size() - 1);
    sets_sent++;
  endtask

  // Keys are drawn from a small pool so that equal keys are common.
  task automatic send_set(input int set_size, input int pool_size);
    logic [epc_pkg::KEY_VALUE_W-1:0] pool [$];
    logic [epc_pkg::KEY_VALUE_W-1:0] base;
    int                              i;
    base = random_key();
    pool.push_back(base);
    for (i = 1; i < pool_size; i++) begin
      // Some pool keys differ from the first in one bit only.
      if ($urandom_range(2) == 0)
        pool.push_back(base ^ (epc_pkg::KEY_VALUE_W'(1) <<
                               $urandom_range(epc_pkg::KEY_VALUE_W - 1)));
      else
        pool.push_back(random_key());
    end
    for (i = 0; i < set_size; i++)
      send_word(pool[$urandom_range(pool_size - 1)], i == set_size - 1);
    sets_sent++;
  endtask

  task automatic random_sets(input int item_budget);
    int sent;
    int set_size;
    sent = 0;
    while (sent < item_budget) begin
      // Mostly short sets; now and then a longer one so the sweep runs deeper.
      set_size = ($urandom_range(9) == 0) ? $urandom_range(13, 48) : $urandom_range(1, 12);
      send_set(set_size, $urandom_range(1, set_size));
      sent += set_size;
    end
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (pending_results != 0) @(negedge clk);
  endtask

  initial begin : key_source
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.key_value = '0;
    in_ch.set_end   = 1'b0;
    send_idle_pct   = 0;
    recv_idle_pct   = 0;
    long_hold_req   = 1'b0;
    sets_sent       = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_idle_pct = 36;
    recv_idle_pct = 75;
    send_listed('{36'h0});
    send_listed('{KEY_ONES});
    send_listed('{36'h0, 36'h0});
    send_listed('{KEY_ONES, KEY_ONES, KEY_ONES});
    // Keys that differ only in the top or bottom bit must not match.
    send_listed('{36'h8_0000_0000, 36'h0, 36'h0_0000_0001, 36'h8_0000_0000});
    send_listed('{36'hA_AAAA_AAAA, 36'h5_5555_5555, 36'hA_AAAA_AAAA, 36'h5_5555_5555,
                  36'hA_AAAA_AAAA});
    send_listed('{36'h7, 36'h7, 36'h9, 36'h9, 36'h9, 36'h7});
    random_sets(PHASE_ITEMS);
    wait_drained();

    send_idle_pct = 75;
    recv_idle_pct = 36;
    random_sets(PHASE_ITEMS);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    long_hold_req = 1'b1;
    random_sets(PHASE_ITEMS);

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Sent %0d key words in %0d sets under three stall mixes and a %0d-cycle hold-off.",
             keys_seen, sets_sent, HOLD_CYCLES);
    $display("Checked %0d result words (%0d with dropped keys), largest pair count %0d.",
             results_seen, dropped_sets, top_pair_count);
    if (fail_count == 0 && pending_results == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
